>>> rtl/sbt_pkg.sv
package sbt_pkg;

	localparam int CNT_W = 5;

	localparam logic [1:0] OP_SUBSCRIBE = 2'd0;
	localparam logic [1:0] OP_TICK      = 2'd1;
	localparam logic [1:0] OP_LIST      = 2'd2;
	localparam logic [1:0] OP_NONE      = 2'd3;

	localparam logic [2:0] ST_REFRESHED  = 3'd0;
	localparam logic [2:0] ST_ADDED      = 3'd1;
	localparam logic [2:0] ST_FULL       = 3'd2;
	localparam logic [2:0] ST_TICK_DONE  = 3'd3;
	localparam logic [2:0] ST_LIST_ENTRY = 3'd4;
	localparam logic [2:0] ST_LIST_EMPTY = 3'd5;

	localparam logic [7:0] DEFAULT_TIMEOUT = 8'd40;
	localparam logic [7:0] AGE_MAX         = 8'hFF;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] client_ip;
		logic [15:0] client_port;
		logic [31:0] client_tag;
	} request_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [31:0]      entry_ip;
		logic [15:0]      entry_port;
		logic [31:0]      entry_tag;
		logic [CNT_W-1:0] removed_count;
		logic [CNT_W-1:0] active_count;
		logic             last;
	} result_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [15:0] port;
		logic [31:0] tag;
		logic [7:0]  age;
	} entry_t;

endpackage

>>> rtl/subscriber_table_with_aging.sv
// Subscriber table with aging.
// Request channel: a request (opcode, client_ip, client_port, client_tag) is
// taken at a rising edge with start high and busy low. Busy rises the next
// cycle and stays high while the request is worked on. Opcode 3 is taken and
// ignored: no result, busy stays low.
// Result channel: each result appears on result for one cycle with valid
// high; the receiver cannot stall, so results are never held back. A list
// request gives one result per entry in subscription order, others give one
// result; result.last marks the final one.
// Timing: one table entry is read per cycle from a table memory with one write
// and one registered read port; compare and age update share one evaluation
// stage. A subscribe that matches an entry ends the scan at that entry.
// A subscribe or tick result follows in the cycle after busy falls. List
// entries come one per cycle in subscription order; the last one is out in the
// first cycle with busy low.
// Configuration: cfg_we writes cfg_data into the timeout limit; write it only
// while idle. Reset clears the entry count and sets the timeout limit to 40;
// table contents are not cleared.
module subscriber_table_with_aging #(
	parameter int MAX_CLIENTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  sbt_pkg::request_t request,
	output logic              busy,
	output logic              valid,
	output sbt_pkg::result_t  result,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_data
);

	logic [7:0]       timeout_q;
	logic             res_valid;
	sbt_pkg::result_t res;
	logic             valid_q;
	sbt_pkg::result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= sbt_pkg::DEFAULT_TIMEOUT;
			valid_q   <= 1'b0;
		end else begin
			valid_q <= res_valid;
			if (cfg_we) begin
				timeout_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			result_q <= res;
		end
	end

	sbt_ctrl #(
		.MAX_CLIENTS(MAX_CLIENTS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.request      (request),
		.timeout_limit(timeout_q),
		.busy         (busy),
		.res_valid    (res_valid),
		.res          (res)
	);

	assign valid  = valid_q;
	assign result = result_q;

endmodule

>>> rtl/sbt_ram.sv
module sbt_ram #(
	parameter int WIDTH = 88,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/sbt_ctrl.sv
module sbt_ctrl #(
	parameter int MAX_CLIENTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  sbt_pkg::request_t  request,
	input  logic [7:0]         timeout_limit,
	output logic               busy,
	output logic               res_valid,
	output sbt_pkg::result_t   res
);

	localparam int IW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
	localparam int CW = $clog2(MAX_CLIENTS + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CLIENTS);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic              state_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     rd_idx_q;
	logic [CW-1:0]     kept_q;
	logic [CW-1:0]     removed_q;
	sbt_pkg::request_t req_q;
	logic              ev_s1;
	logic [IW-1:0]     ev_idx_s1;
	logic              res_valid_q;
	sbt_pkg::result_t  res_q;

	sbt_pkg::entry_t   rdata;
	sbt_pkg::entry_t   wdata;
	logic              ram_we;
	logic [IW-1:0]     waddr;
	logic              issue;
	logic              scan_end;
	logic              match;
	logic              expire;
	logic [7:0]        age_inc;
	logic              is_last;

	function automatic sbt_pkg::result_t mk_result(
		input logic [2:0]    status,
		input logic [CW-1:0] removed,
		input logic [CW-1:0] active
	);
		sbt_pkg::result_t r;
		r = '0;
		r.status        = status;
		r.removed_count = sbt_pkg::CNT_W'(removed);
		r.active_count  = sbt_pkg::CNT_W'(active);
		r.last          = 1'b1;
		return r;
	endfunction

	assign busy      = (state_q == S_SCAN);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign issue    = (state_q == S_SCAN) && (rd_idx_q < cnt_q);
	assign scan_end = (state_q == S_SCAN) && !ev_s1 && (rd_idx_q == cnt_q);
	assign match    = (rdata.ip == req_q.client_ip) && (rdata.port == req_q.client_port);
	assign age_inc  = (rdata.age == sbt_pkg::AGE_MAX) ? sbt_pkg::AGE_MAX : rdata.age + 8'd1;
	assign expire   = (age_inc >= timeout_limit);
	assign is_last  = ((CW'(ev_idx_s1) + CW'(1)) == cnt_q);

	always_comb begin
		ram_we = 1'b0;
		waddr  = ev_idx_s1;
		wdata  = rdata;
		if (ev_s1 && req_q.opcode == sbt_pkg::OP_SUBSCRIBE && match) begin
			ram_we    = 1'b1;
			wdata.age = '0;
		end else if (ev_s1 && req_q.opcode == sbt_pkg::OP_TICK && !expire) begin
			ram_we    = 1'b1;
			waddr     = kept_q[IW-1:0];
			wdata.age = age_inc;
		end else if (scan_end && req_q.opcode == sbt_pkg::OP_SUBSCRIBE && cnt_q < CNT_MAX) begin
			ram_we     = 1'b1;
			waddr      = cnt_q[IW-1:0];
			wdata.ip   = req_q.client_ip;
			wdata.port = req_q.client_port;
			wdata.tag  = req_q.client_tag;
			wdata.age  = '0;
		end
	end

	sbt_ram #(
		.WIDTH($bits(sbt_pkg::entry_t)),
		.DEPTH(MAX_CLIENTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (issue),
		.raddr(rd_idx_q[IW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			kept_q      <= '0;
			removed_q   <= '0;
			ev_s1       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					ev_s1 <= 1'b0;
					if (start && request.opcode != sbt_pkg::OP_NONE) begin
						req_q     <= request;
						rd_idx_q  <= '0;
						kept_q    <= '0;
						removed_q <= '0;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					ev_s1     <= issue;
					ev_idx_s1 <= rd_idx_q[IW-1:0];
					if (issue) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (ev_s1) begin
						unique case (req_q.opcode)
							sbt_pkg::OP_SUBSCRIBE: begin
								if (match) begin
									res_valid_q <= 1'b1;
									res_q       <= mk_result(sbt_pkg::ST_REFRESHED, '0, cnt_q);
									ev_s1       <= 1'b0;
									state_q     <= S_IDLE;
								end
							end
							sbt_pkg::OP_TICK: begin
								if (expire) begin
									removed_q <= removed_q + CW'(1);
								end else begin
									kept_q <= kept_q + CW'(1);
								end
							end
							sbt_pkg::OP_LIST: begin
								res_valid_q      <= 1'b1;
								res_q            <= mk_result(sbt_pkg::ST_LIST_ENTRY, '0, cnt_q);
								res_q.entry_ip   <= rdata.ip;
								res_q.entry_port <= rdata.port;
								res_q.entry_tag  <= rdata.tag;
								res_q.last       <= is_last;
							end
							default: begin
							end
						endcase
					end
					if (scan_end) begin
						state_q <= S_IDLE;
						unique case (req_q.opcode)
							sbt_pkg::OP_SUBSCRIBE: begin
								res_valid_q <= 1'b1;
								if (cnt_q < CNT_MAX) begin
									cnt_q <= cnt_q + CW'(1);
									res_q <= mk_result(sbt_pkg::ST_ADDED, '0, cnt_q + CW'(1));
								end else begin
									res_q <= mk_result(sbt_pkg::ST_FULL, '0, cnt_q);
								end
							end
							sbt_pkg::OP_TICK: begin
								cnt_q       <= kept_q;
								res_valid_q <= 1'b1;
								res_q       <= mk_result(sbt_pkg::ST_TICK_DONE, removed_q, kept_q);
							end
							sbt_pkg::OP_LIST: begin
								if (cnt_q == '0) begin
									res_valid_q <= 1'b1;
									res_q       <= mk_result(sbt_pkg::ST_LIST_EMPTY, '0, cnt_q);
								end
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("entry count above table size");

	a_eval_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ev_s1 |-> (CW'(ev_idx_s1) < cnt_q))
		else $error("evaluated entry beyond entry count");

	a_compact_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_s1 && req_q.opcode == sbt_pkg::OP_TICK) |-> (kept_q <= CW'(ev_idx_s1)))
		else $error("compaction write ahead of scan");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && issue) |-> (waddr != rd_idx_q[IW-1:0]))
		else $error("write and read of same entry in one cycle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.opcode != sbt_pkg::OP_NONE) |=> busy)
		else $error("request accepted without going busy");

endmodule
